// ===== hw/rtl/skvt_pkg.sv =====
// ---------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the sorted key/value table
// Sizes of the entry store, request and status codes, sequencer states.
// ---------------------------------------------------------------------------
package skvt_pkg;

  localparam int CAPACITY   = 128;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int TOTAL_BITS = 8;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DONE
  } state_t;

  // Map a key to a code whose unsigned order is the selected key order.
  function automatic key_t order_code(input key_t k, input logic order_signed);
    order_code = k ^ {order_signed, {(KEY_BITS-1){1'b0}}};
  endfunction

endpackage

// ===== hw/rtl/skvt_store.sv =====
// ---------------------------------------------------------------------------
// skvt_store: entry memory of the sorted key/value table
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module skvt_store (
  input  logic              clk,
  input  logic              wr_en,
  input  skvt_pkg::addr_t   wr_addr,
  input  skvt_pkg::key_t    wr_key,
  input  skvt_pkg::value_t  wr_value,
  input  skvt_pkg::addr_t   rd_addr,
  output skvt_pkg::key_t    rd_key,
  output skvt_pkg::value_t  rd_value
);
  import skvt_pkg::*;

  key_t   key_mem   [CAPACITY];
  value_t value_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/sorted_key_value_table.sv =====
// ---------------------------------------------------------------------------
// sorted_key_value_table: map of up to CAPACITY key/value pairs in key order
// A small sequencer drives one compare unit over an entry memory with one read
// and one write port.
// ---------------------------------------------------------------------------
// One request at a time. A request other than clear scans the stored entries
// from the first position up, reading and then comparing each entry visited,
// and stops at the first equal key; clear skips the scan. An insert then
// moves each entry above the insertion point up (read, write), does a last
// read and places the new pair; a remove moves each entry after the removed
// one down (read, write). A finished result waits in an output register, so
// the next request can start while it is still stalled; a second finished
// result holds the sequencer until that register is free. The user must write
// the key order register only while the table is idle; the block itself does
// not enforce it, and a write does not re-sort stored pairs.
module sorted_key_value_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  action,
  input  skvt_pkg::key_t              key,
  input  skvt_pkg::value_t            value,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [1:0]                  status,
  output logic                        found,
  output skvt_pkg::value_t            old_value,
  output logic                        has_key,
  output logic [skvt_pkg::TOTAL_BITS-1:0] entry_total,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);
  import skvt_pkg::*;

  state_t  state, state_next;
  action_t act, act_next;
  key_t    req_key, req_key_next;
  value_t  req_val, req_val_next;
  count_t  count, count_next;
  count_t  idx, idx_next;
  count_t  pos, pos_next;
  logic    pos_set, pos_set_next;
  logic    hit, hit_next;
  addr_t   hit_idx, hit_idx_next;
  value_t  old, old_next;
  status_t st, st_next;
  logic    key_order_signed;

  logic    wr_en;
  addr_t   wr_addr, rd_addr;
  key_t    wr_key, rd_key;
  value_t  wr_value, rd_value;
  logic    load_rsp;

  skvt_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    act_next     = act;
    req_key_next = req_key;
    req_val_next = req_val;
    count_next   = count;
    idx_next     = idx;
    pos_next     = pos;
    pos_set_next = pos_set;
    hit_next     = hit;
    hit_idx_next = hit_idx;
    old_next     = old;
    st_next      = st;
    wr_en        = 1'b0;
    wr_addr      = idx[ADDR_BITS-1:0];
    wr_key       = rd_key;
    wr_value     = rd_value;
    rd_addr      = idx[ADDR_BITS-1:0];
    load_rsp     = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          act_next     = action_t'(action);
          req_key_next = key;
          req_val_next = value;
          idx_next     = '0;
          pos_next     = count;
          pos_set_next = 1'b0;
          hit_next     = 1'b0;
          old_next     = '0;
          st_next      = ST_OK;
          if (action_t'(action) == ACT_CLEAR) begin
            count_next = '0;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx == count) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (rd_key == req_key) begin
          hit_next     = 1'b1;
          hit_idx_next = idx[ADDR_BITS-1:0];
          old_next     = rd_value;
          state_next   = S_DECIDE;
        end else begin
          if (!pos_set && (order_code(rd_key, key_order_signed) >
                           order_code(req_key, key_order_signed))) begin
            pos_next     = idx;
            pos_set_next = 1'b1;
          end
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        case (act)
          ACT_PUT: begin
            if (hit) begin
              wr_en    = 1'b1;
              wr_addr  = hit_idx;
              wr_key   = req_key;
              wr_value = req_val;
            end else if (count == count_t'(CAPACITY)) begin
              st_next = ST_FULL;
            end else begin
              idx_next   = count;
              state_next = S_SHIFT_RD;
            end
          end
          ACT_REMOVE: begin
            if (hit) begin
              idx_next   = count_t'(hit_idx);
              state_next = S_SHIFT_RD;
            end else begin
              st_next = ST_NOT_FOUND;
            end
          end
          ACT_GET: begin
            if (!hit) st_next = ST_NOT_FOUND;
          end
          default: begin
            st_next = ST_OK;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (act == ACT_PUT) begin
          // move entries up until the insertion point is open
          rd_addr = ADDR_BITS'(idx - 1'b1);
          if (idx == pos) begin
            state_next = S_PLACE;
          end else begin
            state_next = S_SHIFT_WR;
          end
        end else begin
          // move entries down over the removed one
          rd_addr = ADDR_BITS'(idx + 1'b1);
          if (COUNT_BITS'(idx + 1'b1) >= count) begin
            count_next = count - 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_SHIFT_WR;
          end
        end
      end
      S_SHIFT_WR: begin
        wr_en      = 1'b1;
        state_next = S_SHIFT_RD;
        if (act == ACT_PUT) begin
          idx_next = idx - 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = pos[ADDR_BITS-1:0];
        wr_key     = req_key;
        wr_value   = req_val;
        count_next = count + 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      key_order_signed <= 1'b0;
      rsp_valid        <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) key_order_signed <= cfg_data;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act     <= act_next;
    req_key <= req_key_next;
    req_val <= req_val_next;
    idx     <= idx_next;
    pos     <= pos_next;
    pos_set <= pos_set_next;
    hit     <= hit_next;
    hit_idx <= hit_idx_next;
    old     <= old_next;
    st      <= st_next;
    if (load_rsp) begin
      status      <= st;
      found       <= hit;
      old_value   <= old;
      has_key     <= hit && (old != '0);
      entry_total <= TOTAL_BITS'(count);
    end
  end

endmodule

// ===== verif/skvt_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skvt_checker: result predictor and scoreboard for the sorted key/value table
// Watches the request, result and key order channels, keeps its own sorted
// copy of the table, and compares each result transfer field by field with
// the oldest prediction. Hands the number of failures and the number of
// results still outstanding to the testbench top.
// ---------------------------------------------------------------------------
module skvt_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  logic [1:0]                      action,
  input  skvt_pkg::key_t                  key,
  input  skvt_pkg::value_t                value,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  logic [1:0]                      status,
  input  logic                            found,
  input  skvt_pkg::value_t                old_value,
  input  logic                            has_key,
  input  logic [skvt_pkg::TOTAL_BITS-1:0] entry_total,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import skvt_pkg::*;

  typedef struct packed {
    status_t               status;
    logic                  found;
    value_t                old_value;
    logic                  has_key;
    logic [TOTAL_BITS-1:0] entry_total;
  } table_result_t;

  key_t          stored_keys [CAPACITY];
  value_t        stored_values [CAPACITY];
  int            entry_count = 0;
  logic          key_signed = 1'b0;
  table_result_t expected_results [$];
  int            errors = 0;

  // Flip the top bit under signed order so that unsigned compare gives the order.
  function automatic key_t sort_rank(key_t k);
    return key_signed ? {~k[KEY_BITS-1], k[KEY_BITS-2:0]} : k;
  endfunction

  function automatic table_result_t apply_request(action_t act, key_t k, value_t v);
    table_result_t r;
    int            hit;
    int            pos;
    r          = '0;
    r.status   = ST_OK;
    hit        = -1;
    pos        = entry_count;
    if (act != ACT_CLEAR) begin
      for (int i = 0; i < entry_count; i++) begin
        if (hit < 0 && stored_keys[i] == k) hit = i;
      end
    end
    r.found = (hit >= 0);
    if (r.found) r.old_value = stored_values[hit];
    case (act)
      ACT_PUT: begin
        if (r.found) begin
          stored_values[hit] = v;
        end else if (entry_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // insert before the first entry that orders above the new key
          for (int i = entry_count - 1; i >= 0; i--) begin
            if (sort_rank(stored_keys[i]) > sort_rank(k)) pos = i;
          end
          for (int i = entry_count; i > pos; i--) begin
            stored_keys[i]   = stored_keys[i-1];
            stored_values[i] = stored_values[i-1];
          end
          stored_keys[pos]   = k;
          stored_values[pos] = v;
          entry_count++;
        end
      end
      ACT_REMOVE: begin
        if (r.found) begin
          for (int i = hit; i + 1 < entry_count; i++) begin
            stored_keys[i]   = stored_keys[i+1];
            stored_values[i] = stored_values[i+1];
          end
          entry_count--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      ACT_GET: begin
        if (!r.found) r.status = ST_NOT_FOUND;
      end
      default: entry_count = 0;
    endcase
    r.has_key     = r.found && (r.old_value != '0);
    r.entry_total = entry_count[TOTAL_BITS-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      entry_count = 0;
      key_signed  = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) key_signed = cfg_data;
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding: status %0d, total %0d",
                   $time, status, entry_total);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, status);
          compare_field("found", want.found, found);
          compare_field("old_value", want.old_value, old_value);
          compare_field("has_key", want.has_key, has_key);
          compare_field("entry_total", want.entry_total, entry_total);
        end
      end
      if (req_valid && !req_stall)
        expected_results.push_back(apply_request(action_t'(action), key, value));
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench top of the sorted key/value table
// Drives directed requests, a fill of the table to capacity and random
// phases under both key orders and several sender and receiver idle rates;
// the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
  import skvt_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 90;
  localparam int POOL_SIZE    = 32;
  localparam int TAIL_CYCLES  = 600;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  action_t               action = ACT_PUT;
  key_t                  key = '0;
  value_t                value = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [1:0]            status;
  logic                  found;
  value_t                old_value;
  logic                  has_key;
  logic [TOTAL_BITS-1:0] entry_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;
  int                    fail_count;
  int                    pending;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  key_t key_pool [POOL_SIZE];
  key_t fill_keys [CAPACITY];

  always #2 clk = ~clk;

  sorted_key_value_table u_top (
    .clk, .rst, .req_valid, .req_stall, .action, .key, .value,
    .rsp_valid, .rsp_stall, .status, .found, .old_value, .has_key, .entry_total,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  skvt_checker u_checker (
    .clk, .rst, .req_valid, .req_stall, .action, .key, .value,
    .rsp_valid, .rsp_stall, .status, .found, .old_value, .has_key, .entry_total,
    .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
  );

  always @(negedge clk) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

  // End the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sorted_key_value_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(action_t act, key_t k, value_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    key       <= k;
    value     <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key_order(logic signed_order);
    cfg_valid <= 1'b1;
    cfg_data  <= signed_order;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    return $urandom();
  endfunction

  function automatic key_t pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_CLEAR;
    if (r < 45) return ACT_PUT;
    if (r < 65) return ACT_REMOVE;
    return ACT_GET;
  endfunction

  initial begin
    logic [31:0] rnd;
    int          pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, key extremes, zero values, overwrite, miss.
    write_key_order(1'b0);
    send_request(ACT_GET, 32'h0000_0000, 32'h0);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_CLEAR, 32'h0, 32'h0);
    send_request(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_PUT, 32'h8000_0000, 32'h0000_0001);
    send_request(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(ACT_GET, 32'h0000_0000, 32'h5555_5555);
    send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_GET, 32'h0000_0000, 32'h0);
    send_request(ACT_REMOVE, 32'h8000_0000, 32'h0);
    send_request(ACT_REMOVE, 32'h8000_0000, 32'h0);
    send_request(ACT_GET, 32'h1234_5678, 32'h0);
    send_request(ACT_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(ACT_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(ACT_REMOVE, 32'h7FFF_FFFF, 32'h0);
    send_request(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_GET, 32'h0000_0000, 32'h0);
    drain_results();

    // Fill to capacity under signed order; distinct low bits keep keys unique.
    write_key_order(1'b1);
    send_idle_pct = 33;
    stall_pct     = 33;
    for (int i = 0; i < CAPACITY; i++) begin
      rnd          = $urandom();
      fill_keys[i] = {rnd[31:7], 7'(i)};
      send_request(ACT_PUT, fill_keys[i], pick_value());
    end
    for (int j = 0; j < 4; j++) begin
      rnd = $urandom();
      send_request(ACT_PUT, {rnd[31:7], 7'(j)}, pick_value());
    end
    for (int j = 0; j < 24; j++) begin
      rnd  = $urandom();
      pick = $urandom_range(0, 2);
      send_request(action_t'(pick == 0 ? ACT_PUT : (pick == 1 ? ACT_REMOVE : ACT_GET)),
                   $urandom_range(0, 3) != 0 ? fill_keys[$urandom_range(0, CAPACITY - 1)]
                                             : key_t'(rnd),
                   pick_value());
    end
    send_request(ACT_CLEAR, $urandom(), $urandom());
    drain_results();

    // Random phases; pairs stay stored across key order changes.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      write_key_order(((p / 2) % 2) != 0);
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(pick_action(), pick_key(), pick_value());
      drain_results();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_key_value_table test passed");
    end else begin
      $display("sorted_key_value_table test failed");
    end
    $finish;
  end

endmodule
